// ===== rtl/core/imh_pkg.sv =====
// Package for the indexed min-heap: widths, operation and status codes.
// No dependencies.
package imh_pkg;
  localparam int DEPTH = 64;
  localparam int KEY_BITS = 32;
  localparam int HANDLE_BITS = 16;
  localparam int POS_BITS = $clog2(DEPTH);
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_PUSH = 3'd0;
  localparam logic [2:0] OP_POP = 3'd1;
  localparam logic [2:0] OP_PEEK = 3'd2;
  localparam logic [2:0] OP_ERASE = 3'd3;
  localparam logic [2:0] OP_CLEAR = 3'd4;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BAD_POS = 2'd3;

  typedef struct packed {
    logic [1:0] status;
    logic [HANDLE_BITS-1:0] handle;
    logic [KEY_BITS-1:0] key;
    logic [POS_BITS-1:0] position;
    logic removed;
    logic [CNT_BITS-1:0] entry_count;
    logic last;
  } result_t;
endpackage

// ===== rtl/core/imh_store.sv =====
// Slot store of the heap: key and handle memory, one write and one registered read port.
// Depends on imh_pkg.
module imh_store
  import imh_pkg::*;
(
  input  logic clk,
  input  logic we,
  input  logic [POS_BITS-1:0] waddr,
  input  logic [KEY_BITS-1:0] wkey,
  input  logic [HANDLE_BITS-1:0] whandle,
  input  logic [POS_BITS-1:0] raddr,
  output logic [KEY_BITS-1:0] rkey,
  output logic [HANDLE_BITS-1:0] rhandle
);
  logic [KEY_BITS+HANDLE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wkey, whandle};
    end
    {rkey, rhandle} <= mem[raddr];
  end
endmodule

// ===== rtl/core/indexed_min_heap.sv =====
// Top level of the indexed min-heap: sequencer with one shared key comparator around the slot store.
// Depends on imh_pkg and imh_store.
//
//  channel  | handshake            | fields
//  request  | in_valid, in_stall   | operation new_key new_handle erase_position
//  result   | out_valid, out_stall | status handle key position removed entry_count last
//
// One comparator serves every step, and a slot read returns registered data.
// Push lets the new key climb level by level; pop and erase move the last entry down or up
// level by level. Clear emits every held element in turn; peek and an error each give one result.
// A result stall holds the sequencer. Reset clears the count, the sequencer and the result
// valid flag only. The request side is stalled from acceptance until the last result is taken.
module indexed_min_heap
  import imh_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic [2:0] operation,
  input  logic [KEY_BITS-1:0] new_key,
  input  logic [HANDLE_BITS-1:0] new_handle,
  input  logic [POS_BITS-1:0] erase_position,
  output logic out_valid,
  input  logic out_stall,
  output logic [1:0] status,
  output logic [HANDLE_BITS-1:0] handle,
  output logic [KEY_BITS-1:0] key,
  output logic [POS_BITS-1:0] position,
  output logic removed,
  output logic [CNT_BITS-1:0] entry_count,
  output logic last
);
  typedef enum logic [3:0] {
    S_IDLE, S_RD_TOP, S_EMIT_TOP, S_RD_LAST, S_LOAD_LAST, S_DN_L, S_DN_LD, S_DN_PICK,
    S_DN_DEC, S_UP_RD, S_UP_CMP, S_PLACE, S_WAIT
  } state_t;

  state_t state, ret_state;
  logic [CNT_BITS-1:0] count;
  logic [2:0] op;
  logic [KEY_BITS-1:0] cur_key, c_key;
  logic [HANDLE_BITS-1:0] cur_handle, c_handle;
  logic [POS_BITS-1:0] idx, slot, c_pos;
  result_t res;
  logic res_valid;

  logic we;
  logic [POS_BITS-1:0] raddr;
  logic [KEY_BITS-1:0] wkey, rkey;
  logic [HANDLE_BITS-1:0] whandle, rhandle;
  logic [POS_BITS-1:0] parent;
  logic [POS_BITS:0] child_l;
  logic [KEY_BITS-1:0] cmp_a, cmp_b;
  logic lt;
  logic top_last;

  function automatic result_t make_res(input logic [1:0] st,
                                       input logic [HANDLE_BITS-1:0] h,
                                       input logic [KEY_BITS-1:0] k,
                                       input logic [POS_BITS-1:0] pos,
                                       input logic rem,
                                       input logic [CNT_BITS-1:0] cnt,
                                       input logic lst);
    result_t r;
    r.status = st;
    r.handle = h;
    r.key = k;
    r.position = pos;
    r.removed = rem;
    r.entry_count = cnt;
    r.last = lst;
    return r;
  endfunction

  imh_store u_store (
    .clk(clk), .we(we), .waddr(idx), .wkey(wkey), .whandle(whandle),
    .raddr(raddr), .rkey(rkey), .rhandle(rhandle)
  );

  assign parent = (idx - POS_BITS'(1)) >> 1;
  assign child_l = {idx, 1'b1};
  assign top_last = ({1'b0, slot} == count - CNT_BITS'(1));

  assign in_stall = (state != S_IDLE);
  assign out_valid = res_valid;
  assign status = res.status;
  assign handle = res.handle;
  assign key = res.key;
  assign position = res.position;
  assign removed = res.removed;
  assign entry_count = res.entry_count;
  assign last = res.last;

  always_comb begin
    unique case (state)
      S_RD_LAST: raddr = count[POS_BITS-1:0];
      S_DN_L: raddr = child_l[POS_BITS-1:0];
      S_DN_LD: raddr = child_l[POS_BITS-1:0] + POS_BITS'(1);
      S_UP_RD: raddr = parent;
      default: raddr = slot;
    endcase
  end

  always_comb begin
    unique case (state)
      S_DN_PICK: begin
        cmp_a = rkey;
        cmp_b = c_key;
      end
      S_UP_CMP: begin
        cmp_a = cur_key;
        cmp_b = rkey;
      end
      default: begin
        cmp_a = c_key;
        cmp_b = cur_key;
      end
    endcase
  end

  assign lt = (cmp_a < cmp_b);

  always_comb begin
    unique case (state)
      S_DN_DEC: begin
        wkey = c_key;
        whandle = c_handle;
      end
      S_UP_CMP: begin
        wkey = rkey;
        whandle = rhandle;
      end
      default: begin
        wkey = cur_key;
        whandle = cur_handle;
      end
    endcase
  end

  assign we = (state == S_PLACE) || (((state == S_DN_DEC) || (state == S_UP_CMP)) && lt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op <= operation;
            cur_key <= new_key;
            cur_handle <= new_handle;
            case (operation) inside
              OP_PUSH: begin
                if (count == CNT_BITS'(DEPTH)) begin
                  res <= make_res(ST_FULL, '0, '0, '0, 1'b0, count, 1'b1);
                  res_valid <= 1'b1;
                  ret_state <= S_IDLE;
                  state <= S_WAIT;
                end else begin
                  idx <= count[POS_BITS-1:0];
                  count <= count + CNT_BITS'(1);
                  state <= S_UP_RD;
                end
              end
              OP_POP, OP_PEEK: begin
                if (count == '0) begin
                  res <= make_res(ST_EMPTY, '0, '0, '0, 1'b0, count, 1'b1);
                  res_valid <= 1'b1;
                  ret_state <= S_IDLE;
                  state <= S_WAIT;
                end else begin
                  slot <= '0;
                  idx <= '0;
                  state <= S_RD_TOP;
                end
              end
              OP_ERASE: begin
                if ({1'b0, erase_position} >= count) begin
                  res <= make_res(ST_BAD_POS, '0, '0, '0, 1'b0, count, 1'b1);
                  res_valid <= 1'b1;
                  ret_state <= S_IDLE;
                  state <= S_WAIT;
                end else begin
                  slot <= erase_position;
                  idx <= erase_position;
                  state <= S_RD_TOP;
                end
              end
              OP_CLEAR: begin
                if (count == '0) begin
                  res <= make_res(ST_OK, '0, '0, '0, 1'b0, count, 1'b1);
                  res_valid <= 1'b1;
                  ret_state <= S_IDLE;
                  state <= S_WAIT;
                end else begin
                  slot <= '0;
                  state <= S_RD_TOP;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_RD_TOP: state <= S_EMIT_TOP;
        S_EMIT_TOP: begin
          res_valid <= 1'b1;
          state <= S_WAIT;
          if (op == OP_PEEK) begin
            res <= make_res(ST_OK, rhandle, rkey, slot, 1'b0, count, 1'b1);
            ret_state <= S_IDLE;
          end else if (op == OP_CLEAR) begin
            res <= make_res(ST_OK, rhandle, rkey, slot, 1'b1, '0, top_last);
            if (top_last) begin
              count <= '0;
              ret_state <= S_IDLE;
            end else begin
              slot <= slot + POS_BITS'(1);
              ret_state <= S_RD_TOP;
            end
          end else begin
            res <= make_res(ST_OK, rhandle, rkey, slot, 1'b1, count - CNT_BITS'(1), top_last);
            count <= count - CNT_BITS'(1);
            ret_state <= top_last ? S_IDLE : S_RD_LAST;
          end
        end
        S_RD_LAST: state <= S_LOAD_LAST;
        S_LOAD_LAST: begin
          cur_key <= rkey;
          cur_handle <= rhandle;
          state <= S_DN_L;
        end
        S_DN_L: begin
          if (child_l >= count) begin
            state <= (idx == slot) ? S_UP_RD : S_PLACE;
          end else begin
            state <= S_DN_LD;
          end
        end
        S_DN_LD: begin
          c_key <= rkey;
          c_handle <= rhandle;
          c_pos <= child_l[POS_BITS-1:0];
          state <= ((child_l + CNT_BITS'(1)) < count) ? S_DN_PICK : S_DN_DEC;
        end
        S_DN_PICK: begin
          if (lt) begin
            c_key <= rkey;
            c_handle <= rhandle;
            c_pos <= c_pos + POS_BITS'(1);
          end
          state <= S_DN_DEC;
        end
        S_DN_DEC: begin
          if (lt) begin
            res <= make_res(ST_OK, c_handle, c_key, idx, 1'b0, count, 1'b0);
            res_valid <= 1'b1;
            idx <= c_pos;
            ret_state <= S_DN_L;
            state <= S_WAIT;
          end else begin
            state <= (idx == slot) ? S_UP_RD : S_PLACE;
          end
        end
        S_UP_RD: begin
          if (idx == '0) begin
            state <= S_PLACE;
          end else begin
            state <= S_UP_CMP;
          end
        end
        S_UP_CMP: begin
          if (lt) begin
            res <= make_res(ST_OK, rhandle, rkey, idx, 1'b0, count, 1'b0);
            res_valid <= 1'b1;
            idx <= parent;
            ret_state <= S_UP_RD;
            state <= S_WAIT;
          end else begin
            state <= S_PLACE;
          end
        end
        S_PLACE: begin
          res <= make_res(ST_OK, cur_handle, cur_key, idx, 1'b0, count, 1'b1);
          res_valid <= 1'b1;
          ret_state <= S_IDLE;
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (!out_stall) begin
            res_valid <= 1'b0;
            state <= ret_state;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
